// ===== rtl/swc_pkg.sv =====
`default_nettype none

package swc_pkg;

  // Widths of the coordinate grid and of the error counter.
  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 32;

  // Derived arithmetic widths.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int PROD_W  = CROSS_W + DIFF_W;
  localparam int TV_W    = PROD_W + 2;
  localparam int SUM_W   = 64;
  localparam int MAG_W   = 63;
  localparam int SHIFT_W = 6;

  localparam logic [SHIFT_W-1:0] TOL_SHIFT_RESET = SHIFT_W'(30);

  // Multiplier step codes: six cross-product terms, then three dot terms.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CX_SET = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CX_SUB = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CY_SET = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CY_SUB = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CZ_SET = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CZ_SUB = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DOT_X  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DOT_Y  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DOT_Z  = 4'd8;

  // One input word: a triangle and its shell markers.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx_in;
    logic signed [COORD_BITS-1:0] by_in;
    logic signed [COORD_BITS-1:0] bz_in;
    logic signed [COORD_BITS-1:0] cx_in;
    logic signed [COORD_BITS-1:0] cy_in;
    logic signed [COORD_BITS-1:0] cz_in;
    logic                         shell_first;
    logic                         shell_last;
    logic                         exterior_shell;
  } swc_in_t;

  // One result word, given at the end of a shell.
  typedef struct packed {
    logic signed [SUM_W-1:0]  signed_volume;
    logic [MAG_W-1:0]         absolute_sum;
    logic                     degenerate;
    logic                     winding_error;
    logic [COUNT_BITS-1:0]    error_total;
  } swc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic [STEP_W-1:0] step;
    logic              accum;
    logic              finish;
  } swc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } swc_status_t;

endpackage

`default_nettype wire

// ===== rtl/swc_ctrl.sv =====
`default_nettype none

module swc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire swc_pkg::swc_status_t status_i,
  output swc_pkg::swc_cmd_t         cmd_o
);
  import swc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // Next-state logic and command decode.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = STEP_CX_SET;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (step_q == STEP_DOT_Z) begin
          state_d = ST_ACC;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/swc_datapath.sv =====
`default_nettype none

module swc_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire swc_pkg::swc_in_t             in_data_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [swc_pkg::SHIFT_W-1:0]  cfg_data_i,
  input  wire swc_pkg::swc_cmd_t            cmd_i,
  output swc_pkg::swc_status_t              status_o,
  output swc_pkg::swc_out_t                 out_data_o
);
  import swc_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [MAG_W-1:0]        MAG_MAX = '1;
  localparam logic [COUNT_BITS-1:0]   CNT_MAX = '1;

  logic [SHIFT_W-1:0]            tol_shift_q;
  logic signed [COORD_BITS-1:0]  org_x_q, org_y_q, org_z_q;
  logic signed [SUM_W-1:0]       sacc_q;
  logic [MAG_W-1:0]              aacc_q;
  logic                          ext_valid_q, ext_pos_q;
  logic [MAG_W-1:0]              ext_mag_q;
  logic [COUNT_BITS-1:0]         err_cnt_q;
  logic                          last_q, ext_q;
  logic signed [DIFF_W-1:0]      px_q, py_q, pz_q, qx_q, qy_q, qz_q, rx_q, ry_q, rz_q;
  logic signed [CROSS_W-1:0]     cx_q, cy_q, cz_q;
  logic signed [TV_W-1:0]        tv_q;
  swc_out_t                      out_q;

  // Origin for this word: vertex a when the word opens a shell.
  logic signed [COORD_BITS-1:0] ox, oy, oz;
  assign ox = in_data_i.shell_first ? in_data_i.ax : org_x_q;
  assign oy = in_data_i.shell_first ? in_data_i.ay : org_y_q;
  assign oz = in_data_i.shell_first ? in_data_i.az : org_z_q;

  function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_BITS-1:0] v,
                                                    input logic signed [COORD_BITS-1:0] o);
    diff = DIFF_W'(v) - DIFF_W'(o);
  endfunction

  // Shared multiplier and its operand selection.
  logic signed [CROSS_W-1:0] mul_a;
  logic signed [DIFF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    case (cmd_i.step)
      STEP_CX_SET: begin mul_a = CROSS_W'(qy_q); mul_b = rz_q; end
      STEP_CX_SUB: begin mul_a = CROSS_W'(qz_q); mul_b = ry_q; end
      STEP_CY_SET: begin mul_a = CROSS_W'(qz_q); mul_b = rx_q; end
      STEP_CY_SUB: begin mul_a = CROSS_W'(qx_q); mul_b = rz_q; end
      STEP_CZ_SET: begin mul_a = CROSS_W'(qx_q); mul_b = ry_q; end
      STEP_CZ_SUB: begin mul_a = CROSS_W'(qy_q); mul_b = rx_q; end
      STEP_DOT_X:  begin mul_a = cx_q;           mul_b = px_q; end
      STEP_DOT_Y:  begin mul_a = cy_q;           mul_b = py_q; end
      STEP_DOT_Z:  begin mul_a = cz_q;           mul_b = pz_q; end
      default:     begin mul_a = '0;             mul_b = '0;   end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Saturating accumulation of the triple product.
  logic signed [SUM_W:0]   ssum;
  logic signed [SUM_W-1:0] sacc_next;
  logic signed [TV_W-1:0]  tv_abs;
  logic [MAG_W:0]          asum;
  logic [MAG_W-1:0]        aacc_next;

  assign ssum      = (SUM_W+1)'(sacc_q) + (SUM_W+1)'(tv_q);
  assign sacc_next = (ssum[SUM_W] != ssum[SUM_W-1]) ? (ssum[SUM_W] ? SUM_MIN : SUM_MAX)
                                                    : ssum[SUM_W-1:0];
  assign tv_abs    = tv_q[TV_W-1] ? -tv_q : tv_q;
  assign asum      = {1'b0, aacc_q} + (MAG_W+1)'(tv_abs);
  assign aacc_next = asum[MAG_W] ? MAG_MAX : asum[MAG_W-1:0];

  // End-of-shell evaluation.
  logic [MAG_W-1:0]      smag, tol;
  logic                  sacc_zero, sacc_pos, degen, werr;
  logic [COUNT_BITS-1:0] cnt_next;

  always_comb begin
    logic signed [SUM_W-1:0] neg;
    neg       = -sacc_q;
    sacc_zero = (sacc_q == '0);
    sacc_pos  = !sacc_q[SUM_W-1] && !sacc_zero;
    if (sacc_q == SUM_MIN) begin
      smag = MAG_MAX;
    end else if (sacc_q[SUM_W-1]) begin
      smag = neg[MAG_W-1:0];
    end else begin
      smag = sacc_q[MAG_W-1:0];
    end
    tol   = aacc_q >> tol_shift_q;
    degen = (aacc_q == '0) || sacc_zero || (smag < tol);
    werr  = !ext_q && ext_valid_q && !degen
            && ((sacc_pos == ext_pos_q) || (smag >= ext_mag_q));
    cnt_next = (werr && (err_cnt_q != CNT_MAX)) ? err_cnt_q + COUNT_BITS'(1) : err_cnt_q;
  end

  // Configuration and persistent shell state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_shift_q <= TOL_SHIFT_RESET;
      org_x_q     <= '0;
      org_y_q     <= '0;
      org_z_q     <= '0;
      sacc_q      <= '0;
      aacc_q      <= '0;
      ext_valid_q <= 1'b0;
      ext_pos_q   <= 1'b0;
      ext_mag_q   <= '0;
      err_cnt_q   <= '0;
      last_q      <= 1'b0;
      ext_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_shift_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        last_q <= in_data_i.shell_last;
        ext_q  <= in_data_i.exterior_shell;
        if (in_data_i.shell_first) begin
          org_x_q <= in_data_i.ax;
          org_y_q <= in_data_i.ay;
          org_z_q <= in_data_i.az;
          sacc_q  <= '0;
          aacc_q  <= '0;
        end
      end
      if (cmd_i.accum) begin
        sacc_q <= sacc_next;
        aacc_q <= aacc_next;
      end
      if (cmd_i.finish) begin
        err_cnt_q <= cnt_next;
        if (ext_q) begin
          ext_valid_q <= !degen;
          ext_pos_q   <= sacc_pos;
          ext_mag_q   <= degen ? '0 : smag;
        end
      end
    end
  end

  // Operand, product and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= diff(in_data_i.ax, ox);
      py_q <= diff(in_data_i.ay, oy);
      pz_q <= diff(in_data_i.az, oz);
      qx_q <= diff(in_data_i.bx_in, ox);
      qy_q <= diff(in_data_i.by_in, oy);
      qz_q <= diff(in_data_i.bz_in, oz);
      rx_q <= diff(in_data_i.cx_in, ox);
      ry_q <= diff(in_data_i.cy_in, oy);
      rz_q <= diff(in_data_i.cz_in, oz);
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.step)
        STEP_CX_SET: cx_q <= CROSS_W'(prod);
        STEP_CX_SUB: cx_q <= cx_q - CROSS_W'(prod);
        STEP_CY_SET: cy_q <= CROSS_W'(prod);
        STEP_CY_SUB: cy_q <= cy_q - CROSS_W'(prod);
        STEP_CZ_SET: cz_q <= CROSS_W'(prod);
        STEP_CZ_SUB: cz_q <= cz_q - CROSS_W'(prod);
        STEP_DOT_X:  tv_q <= TV_W'(prod);
        STEP_DOT_Y:  tv_q <= tv_q + TV_W'(prod);
        STEP_DOT_Z:  tv_q <= tv_q + TV_W'(prod);
        default:     tv_q <= tv_q;
      endcase
    end
    if (cmd_i.finish) begin
      out_q.signed_volume <= sacc_q;
      out_q.absolute_sum  <= aacc_q;
      out_q.degenerate    <= degen;
      out_q.winding_error <= werr;
      out_q.error_total   <= cnt_next;
    end
  end

  assign status_o.last = last_q;
  assign out_data_o    = out_q;

endmodule

`default_nettype wire

// ===== rtl/shell_winding_check.sv =====
`default_nettype none

// Shell winding check: signed volume of the shells of a triangle mesh.
// Input channel in_valid_i/in_ready_o carries one word per triangle: three
// grid vertices and the first, last and exterior markers of its shell.
// Output channel out_valid_o/out_ready_i carries one word per closed shell:
// the saturated signed and absolute sums, the degenerate and winding-error
// flags and the running error count.
// After a triangle is accepted, no further word is accepted until it is done:
// a single shared multiplier works through six cross-product terms and three
// dot terms, then an accumulation step follows and, when the triangle closes
// a shell, an evaluation step. The result sits in an output register, so a
// new triangle is taken while it waits; if the receiver still stalls when
// the next shell closes, the block holds that shell in its evaluation step
// until the register frees. cfg_we_i writes the degeneracy shift cfg_data_i
// (reset value 30). It is to be used only while the block is idle; the block
// itself does not enforce this. Reset clears all sums, the origin, the
// exterior record and the error count.
module shell_winding_check (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire swc_pkg::swc_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output swc_pkg::swc_out_t                out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [swc_pkg::SHIFT_W-1:0] cfg_data_i
);
  import swc_pkg::*;

  swc_cmd_t    cmd;
  swc_status_t status;

  // Sequencer.
  swc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and shell state.
  swc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // After a word is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a triangle is in progress");

  // A flagged winding error has always been counted.
  a_err_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.winding_error) |-> (out_data_o.error_total != '0))
    else $error("winding error given with a zero error count");

  // A degenerate shell is never checked for winding.
  a_degen_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |-> !out_data_o.winding_error)
    else $error("winding error on a degenerate shell");

  // A non-degenerate shell has a non-zero absolute sum.
  a_abs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.degenerate) |-> (out_data_o.absolute_sum != '0))
    else $error("non-degenerate shell with zero absolute sum");
`endif

endmodule

`default_nettype wire
